// ===== rtl/lbpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpd_pkg: shared types and constants for the LCD bus pixel decoder
// Display geometry, command codes, decode modes and the result word layout.
// ----------------------------------------------------------------------------
package lbpd_pkg;

  localparam int DISPLAY_WIDTH  = 176;   // 1 .. 256
  localparam int DISPLAY_HEIGHT = 208;   // 1 .. 256

  localparam int BYTE_W  = 8;
  localparam int NIB_W   = 4;
  localparam int COL_W   = 8;
  localparam int LINE_W  = 9;
  localparam int ROW_W   = 8;
  localparam int COLOR_W = 16;
  localparam int LATCH_W = 3;
  localparam int NCNT_W  = 2;

  localparam logic [BYTE_W-1:0]  CMD_LINE_LATCH = 8'h75;
  localparam logic [BYTE_W-1:0]  CMD_PIXEL      = 8'h5C;
  localparam logic [LINE_W-1:0]  LINE_MAX       = 9'd511;
  localparam logic [LATCH_W-1:0] LATCH_MAX      = 3'd7;

  // color bit positions for r, g, b nibbles
  localparam int RED_POS   = 12;
  localparam int GREEN_POS = 7;
  localparam int BLUE_POS  = 1;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_LATCH = 2'd1,
    MODE_PIXEL = 2'd2
  } decode_mode_t;

  typedef struct packed {
    logic [COL_W-1:0]   x;
    logic [ROW_W-1:0]   y;
    logic [COLOR_W-1:0] color;
  } pixel_t;

endpackage

// ===== rtl/lbpd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpd_in_if: captured bus channel
// One word is a data bus byte plus the bus mode flag.
// ----------------------------------------------------------------------------
interface lbpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_byte;
  logic       mode_flag;

  modport source (output valid, output bus_byte, output mode_flag, input ready);
  modport sink   (input valid, input bus_byte, input mode_flag, output ready);
endinterface

// ===== rtl/lbpd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpd_out_if: decoded pixel channel
// One word is a pixel position and its RGB565 color.
// ----------------------------------------------------------------------------
interface lbpd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [15:0] pixel_color;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                  output ready);
endinterface

// ===== rtl/lbpd_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpd_skid: output register with skid stage
// Holds one pixel for the receiver and parks one more while it stalls.
// ----------------------------------------------------------------------------
module lbpd_skid (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  lbpd_pkg::pixel_t in_data,
  output logic            in_ready,
  output logic            out_valid,
  output lbpd_pkg::pixel_t out_data,
  input  logic            out_ready
);
  import lbpd_pkg::*;

  logic   skid_valid;
  pixel_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_valid) begin
        out_data <= in_data;
      end
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

// ===== rtl/lcd_bus_pixel_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_bus_pixel_decoder_core: captured LCD bus to pixel decoder
// Usage:
//   bus   : sink of captured bus words (bus_byte, mode_flag). mode_flag low
//           marks a command strobe: 0x75 starts a line latch and clears the
//           position counters, 0x5C starts pixel data, others go idle.
//   pixel : source of decoded pixels (pixel_x, pixel_y, pixel_color RGB565).
//           Every three data nibbles give one pixel; off-screen pixels and
//           words that complete no pixel give no output word.
//   Throughput: one bus word per cycle while bus.ready is high. The decode state is
//   updated in the cycle a word is accepted.
//   Output: a completed pixel is registered in the output register, or in
//   the skid register while the receiver stalls.
//   Stall: a two-entry output stage (register plus skid) keeps bus.ready
//   high while one pixel waits; ready drops only when both are full.
//   Reset: synchronous rst returns to idle with all counters at zero and
//   empties the output stage.
// ----------------------------------------------------------------------------
module lcd_bus_pixel_decoder_core (
  input logic            clk,
  input logic            rst,
  lbpd_in_if.sink        bus,
  lbpd_out_if.source     pixel
);
  import lbpd_pkg::*;

  decode_mode_t         mode, mode_next;
  logic [LATCH_W-1:0]   latch_count, latch_count_next;
  logic [ROW_W-1:0]     row_base, row_base_next;
  logic [BYTE_W-1:0]    held, held_next;
  logic [NCNT_W-1:0]    nib_count, nib_count_next;
  logic [COL_W-1:0]     column, column_next;
  logic [LINE_W-1:0]    line, line_next;

  logic                 accept;
  logic                 skid_ready;
  logic                 emit;
  logic                 res_valid;
  pixel_t               res;
  pixel_t               out_data;
  logic [NIB_W-1:0]     r, g, b;
  logic [NIB_W-1:0]     hi, lo;
  logic [COL_W:0]       col_inc;
  logic [ROW_W+1:0]     row_sum;
  logic                 on_screen;

  assign accept    = bus.valid && skid_ready;
  assign bus.ready = skid_ready;
  assign hi        = bus.bus_byte[7:4];
  assign lo        = bus.bus_byte[3:0];

  // next mode
  always_comb begin
    mode_next = mode;
    if (accept && !bus.mode_flag) begin
      case (bus.bus_byte)
        CMD_LINE_LATCH: mode_next = MODE_LATCH;
        CMD_PIXEL:      mode_next = MODE_PIXEL;
        default:        mode_next = MODE_IDLE;
      endcase
    end
  end

  // pixel assembly from held nibbles and the new byte
  always_comb begin
    case (nib_count)
      2'd1: begin
        r = held[3:0];
        g = hi;
        b = lo;
      end
      2'd2: begin
        r = held[7:4];
        g = held[3:0];
        b = hi;
      end
      default: begin
        r = held[3:0];
        g = hi;
        b = lo;
      end
    endcase
  end

  assign col_inc   = {1'b0, column} + (COL_W+1)'(1);
  assign row_sum   = (ROW_W+2)'(row_base) + (ROW_W+2)'(line);
  assign on_screen = ({1'b0, column} < (COL_W+1)'(DISPLAY_WIDTH)) &&
                     (row_sum < (ROW_W+2)'(DISPLAY_HEIGHT));

  assign res.x     = column;
  assign res.y     = row_sum[ROW_W-1:0];
  assign res.color = (COLOR_W'(r) << RED_POS) | (COLOR_W'(g) << GREEN_POS) |
                     (COLOR_W'(b) << BLUE_POS);

  // datapath next values and result
  always_comb begin
    latch_count_next = latch_count;
    row_base_next    = row_base;
    held_next        = held;
    nib_count_next   = nib_count;
    column_next      = column;
    line_next        = line;
    emit             = 1'b0;
    if (accept) begin
      if (!bus.mode_flag) begin
        latch_count_next = '0;
        if (bus.bus_byte == CMD_LINE_LATCH) begin
          held_next      = '0;
          nib_count_next = '0;
          column_next    = '0;
          line_next      = '0;
        end
      end else if (mode == MODE_LATCH || mode == MODE_PIXEL) begin
        if (latch_count != LATCH_MAX) begin
          latch_count_next = latch_count + LATCH_W'(1);
        end
        if (mode == MODE_LATCH) begin
          if (latch_count == '0) begin
            row_base_next = bus.bus_byte;
          end
        end else begin
          case (nib_count)
            2'd1: begin
              emit           = 1'b1;
              held_next      = '0;
              nib_count_next = 2'd0;
            end
            2'd2: begin
              emit           = 1'b1;
              held_next      = {4'd0, lo};
              nib_count_next = 2'd1;
            end
            default: begin
              held_next      = bus.bus_byte;
              nib_count_next = 2'd2;
            end
          endcase
          if (emit) begin
            if (col_inc >= (COL_W+1)'(DISPLAY_WIDTH)) begin
              column_next = '0;
              if (line != LINE_MAX) begin
                line_next = line + LINE_W'(1);
              end
            end else begin
              column_next = col_inc[COL_W-1:0];
            end
          end
        end
      end
    end
  end

  assign res_valid = emit && on_screen;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      latch_count <= '0;
      row_base    <= '0;
      held        <= '0;
      nib_count   <= '0;
      column      <= '0;
      line        <= '0;
    end else begin
      mode        <= mode_next;
      latch_count <= latch_count_next;
      row_base    <= row_base_next;
      held        <= held_next;
      nib_count   <= nib_count_next;
      column      <= column_next;
      line        <= line_next;
    end
  end

  lbpd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .in_ready  (skid_ready),
    .out_valid (pixel.valid),
    .out_data  (out_data),
    .out_ready (pixel.ready)
  );

  assign pixel.pixel_x     = out_data.x;
  assign pixel.pixel_y     = out_data.y;
  assign pixel.pixel_color = out_data.color;

endmodule
